// ----- sv/ntpcal_pkg.sv -----
// ----------------------------------------------------------------------------
// ntpcal_pkg
// Shared types, constants and helper functions for the NTP seconds to
// calendar converter.
// ----------------------------------------------------------------------------
package ntpcal_pkg;

  localparam int SECS_W  = 32;
  localparam int ZONE_W  = 17;
  localparam int LOCAL_W = 33;
  localparam int QUO_W   = 17;
  localparam int DAYS_W  = 17;
  localparam int CNT_W   = 1;
  localparam int NUM_W   = 26;
  localparam int DIVR_W  = 10;

  localparam logic [ZONE_W-1:0] ZONE_RESET = 17'h1D5B0;  // -10832, not exactly UTC-3 (-10800)

  localparam logic [10:0] BASE_YEAR   = 11'd1900;
  localparam logic [1:0]  BASE_MOD4   = 2'd0;    // 1900 mod 4
  localparam logic [6:0]  BASE_MOD100 = 7'd0;    // 1900 mod 100
  localparam logic [8:0]  BASE_MOD400 = 9'd300;  // 1900 mod 400
  localparam logic [6:0]  LAST_MOD100 = 7'd99;
  localparam logic [8:0]  LAST_MOD400 = 9'd399;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [8:0] DAYS_YEAR      = 9'd365;
  localparam logic [8:0] DAYS_LEAP_YEAR = 9'd366;

  // Each constant divisor is an odd part shifted up by a power of two. The
  // odd part is divided by multiplying with floor(2^k / d), which lands at
  // most one short of the true quotient; one compare and subtract fixes it.
  localparam int DIV_STEPS = 2;

  localparam logic [DIVR_W-1:0] DAY_ODD    = 10'd675;    // 86400 = 675 << 7
  localparam logic [16:0]       DAY_RECIP  = 17'd99420;  // floor(2^26 / 675)
  localparam logic [DIVR_W-1:0] HOUR_ODD   = 10'd225;    // 3600 = 225 << 4
  localparam logic [5:0]        HOUR_RECIP = 6'd36;      // floor(2^13 / 225)
  localparam logic [DIVR_W-1:0] MIN_ODD    = 10'd15;     // 60 = 15 << 2
  localparam logic [6:0]        MIN_RECIP  = 7'd68;      // floor(2^10 / 15)
  localparam logic [DIVR_W-1:0] WEEK_ODD   = 10'd7;
  localparam logic [13:0]       WEEK_RECIP = 14'd9362;   // floor(2^16 / 7)

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV_DAY,
    S_DIV_HOUR,
    S_DIV_MIN,
    S_DIV_WEEK,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_HOUR,
    DIV_MIN,
    DIV_WEEK
  } div_sel_t;

  typedef struct packed {
    logic             load;
    logic             step;
    logic             last;
    div_sel_t         sel;
    logic             year_step;
    logic             month_step;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic out_free;
  } stat_t;

  function automatic logic [DIVR_W-1:0] div_odd(input div_sel_t sel);
    logic [DIVR_W-1:0] b;
    case (sel)
      DIV_DAY:  b = DAY_ODD;
      DIV_HOUR: b = HOUR_ODD;
      DIV_MIN:  b = MIN_ODD;
      DIV_WEEK: b = WEEK_ODD;
      default:  b = WEEK_ODD;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] l;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   l = 5'd30;
      4'd2:                                      l = leap ? 5'd29 : 5'd28;
      default:                                   l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

// ----- sv/ntpcal_dp.sv -----
// ----------------------------------------------------------------------------
// ntpcal_dp
// Datapath: zone offset register, reciprocal-multiply constant dividers,
// year and month walk, and the result register.
// ----------------------------------------------------------------------------
module ntpcal_dp import ntpcal_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [SECS_W-1:0] ntp_seconds,
  input  logic              cfg_we,
  input  logic [ZONE_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [10:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second,
  output logic [2:0]        weekday
);

  logic [ZONE_W-1:0]  zone;
  logic [LOCAL_W-1:0] rem;
  logic [QUO_W-1:0]   quo;
  logic [DAYS_W-1:0]  total_days;
  logic [DAYS_W-1:0]  days;
  logic [10:0]        yr;
  logic [1:0]         mod4;
  logic [6:0]         mod100;
  logic [8:0]         mod400;
  logic [3:0]         mon;
  logic [4:0]         hr;
  logic [5:0]         mn;
  logic [5:0]         sc;
  logic [2:0]         wd;

  logic signed [LOCAL_W:0]   sum;
  logic [LOCAL_W-1:0]        local_secs;
  logic [42:0]               prod_day;
  logic [18:0]               prod_hour;
  logic [16:0]               prod_min;
  logic [29:0]               prod_week;
  logic [NUM_W-1:0]          num;
  logic [QUO_W-1:0]          est;
  logic [DIVR_W-1:0]         odd;
  logic [QUO_W+DIVR_W-1:0]   back;
  logic [NUM_W-1:0]          diff;
  logic                      ge;
  logic [QUO_W-1:0]          quo_fix;
  logic [DIVR_W-1:0]         rem_fix;
  logic                      leap;
  logic [8:0]                ylen;
  logic [4:0]                mlen;

  // clamp a negative local time to the epoch
  assign sum        = $signed({2'b00, ntp_seconds}) + (LOCAL_W+1)'($signed(zone));
  assign local_secs = sum[LOCAL_W] ? '0 : sum[LOCAL_W-1:0];

  assign prod_day  = {17'b0, rem[LOCAL_W-1:7]} * {26'b0, DAY_RECIP};
  assign prod_hour = {6'b0, rem[16:4]} * {13'b0, HOUR_RECIP};
  assign prod_min  = {7'b0, rem[11:2]} * {10'b0, MIN_RECIP};
  assign prod_week = {14'b0, rem[15:0]} * {16'b0, WEEK_RECIP};

  // numerator is the running value with the power-of-two part dropped
  always_comb begin
    case (cmd.sel)
      DIV_DAY: begin
        num = rem[LOCAL_W-1:7];
        est = prod_day[42:26];
      end
      DIV_HOUR: begin
        num = {13'b0, rem[16:4]};
        est = {11'b0, prod_hour[18:13]};
      end
      DIV_MIN: begin
        num = {16'b0, rem[11:2]};
        est = {10'b0, prod_min[16:10]};
      end
      DIV_WEEK: begin
        num = {10'b0, rem[15:0]};
        est = {3'b0, prod_week[29:16]};
      end
      default: begin
        num = '0;
        est = '0;
      end
    endcase
  end

  // the estimate is short by at most one: fix it with one compare and subtract
  assign odd     = div_odd(cmd.sel);
  assign back    = {{DIVR_W{1'b0}}, quo} * {{QUO_W{1'b0}}, odd};
  assign diff    = num - back[NUM_W-1:0];
  assign ge      = diff >= NUM_W'(odd);
  assign quo_fix = quo + QUO_W'(ge);
  assign rem_fix = ge ? DIVR_W'(diff - NUM_W'(odd)) : DIVR_W'(diff);

  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign ylen = leap ? DAYS_LEAP_YEAR : DAYS_YEAR;
  assign mlen = month_len(mon, leap && (mon == MONTH_FEB));

  assign stat.year_done  = days < DAYS_W'(ylen);
  assign stat.month_done = (mon == MONTH_DEC) || (days < DAYS_W'(mlen));
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= ZONE_RESET;
    end else if (cfg_we) begin
      zone <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem <= local_secs;
      quo <= '0;
    end else if (cmd.step) begin
      if (!cmd.last) begin
        quo <= est;
      end else begin
        case (cmd.sel)
          DIV_DAY: begin
            total_days <= quo_fix;
            days       <= quo_fix;
            // seconds of day: odd remainder back above the dropped low bits
            rem        <= {16'b0, rem_fix, rem[6:0]};
          end
          DIV_HOUR: begin
            hr  <= quo_fix[4:0];
            rem <= {21'b0, rem_fix[7:0], rem[3:0]};
          end
          DIV_MIN: begin
            mn  <= quo_fix[5:0];
            sc  <= {rem_fix[3:0], rem[1:0]};
            // day count shifted so that the epoch lands on Monday
            rem <= LOCAL_W'(total_days) + LOCAL_W'(1);
          end
          DIV_WEEK: begin
            wd     <= rem_fix[2:0];
            yr     <= BASE_YEAR;
            mod4   <= BASE_MOD4;
            mod100 <= BASE_MOD100;
            mod400 <= BASE_MOD400;
            mon    <= MONTH_JAN;
          end
          default: begin
            rem <= rem;
          end
        endcase
      end
    end else if (cmd.year_step && !stat.year_done) begin
      days   <= days - DAYS_W'(ylen);
      yr     <= yr + 11'd1;
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
    end else if (cmd.month_step && !stat.month_done) begin
      days <= days - DAYS_W'(mlen);
      mon  <= mon + 4'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      year         <= yr;
      month        <= mon;
      day_of_month <= days[4:0] + 5'd1;
      hour         <= hr;
      minute       <= mn;
      second       <= sc;
      weekday      <= wd;
    end
  end

endmodule

// ----- sv/ntpcal_ctrl.sv -----
// ----------------------------------------------------------------------------
// ntpcal_ctrl
// Controller: sequences the divider phases, the year walk, the month walk
// and the hand-off to the result register.
// ----------------------------------------------------------------------------
module ntpcal_ctrl import ntpcal_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    cmd            = '0;
    cmd.sel        = DIV_DAY;
    cmd.last       = (cnt == '0);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          cnt_next   = CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV_DAY;
        end
      end
      S_DIV_DAY: begin
        cmd.step = 1'b1;
        cmd.sel  = DIV_DAY;
        cnt_next = cnt - 1'b1;
        if (cmd.last) begin
          cnt_next   = CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV_HOUR;
        end
      end
      S_DIV_HOUR: begin
        cmd.step = 1'b1;
        cmd.sel  = DIV_HOUR;
        cnt_next = cnt - 1'b1;
        if (cmd.last) begin
          cnt_next   = CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV_MIN;
        end
      end
      S_DIV_MIN: begin
        cmd.step = 1'b1;
        cmd.sel  = DIV_MIN;
        cnt_next = cnt - 1'b1;
        if (cmd.last) begin
          cnt_next   = CNT_W'(DIV_STEPS - 1);
          state_next = S_DIV_WEEK;
        end
      end
      S_DIV_WEEK: begin
        cmd.step = 1'b1;
        cmd.sel  = DIV_WEEK;
        cnt_next = cnt - 1'b1;
        if (cmd.last) begin
          cnt_next   = '0;
          state_next = S_YEAR;
        end
      end
      S_YEAR: begin
        cmd.year_step = 1'b1;
        if (stat.year_done) begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        cmd.month_step = 1'b1;
        if (stat.month_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ntp_seconds_to_calendar_top.sv -----
// ----------------------------------------------------------------------------
// ntp_seconds_to_calendar_top
// Converts an NTP seconds count plus a signed zone offset into local
// calendar date, time of day and day of week. One request is converted at a
// time. A request is loaded, goes through four constant divisions (days,
// hours, minutes, weekday), each a reciprocal multiply and a one-step
// correction, then a year walk and a month walk, one year or month per
// cycle, and waits while the result register is stalled. The walks cover up
// to 136 whole years past 1900 and up to month index 11. The result sits in
// an output register, so a new request is taken while the previous result
// is still stalled. Local times below zero clamp to 1900-01-01.
// ----------------------------------------------------------------------------
module ntp_seconds_to_calendar_top import ntpcal_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SECS_W-1:0] ntp_seconds,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ZONE_W-1:0] zone_offset_seconds,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [10:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day_of_month,
  output logic [4:0]        hour,
  output logic [5:0]        minute,
  output logic [5:0]        second,
  output logic [2:0]        weekday
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = !rst;

  ntpcal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ntpcal_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .ntp_seconds  (ntp_seconds),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (zone_offset_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NTP seconds to calendar converter. Requests
// go in under several zone offsets (reset value, range ends, full 17-bit
// ends, random), first a directed set of calendar edges, then random times
// biased toward year and month boundaries. Each result is checked field by
// field against a calendar computed here, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import ntpcal_pkg::*;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;
  localparam int FIRST_YEAR    = 1900;
  localparam int PHASE_ITEMS   = 80;
  localparam int IDLE_LIMIT    = 4000;
  localparam int DRAIN_CYCLES  = 250;
  localparam int PRINT_CAP     = 100;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
  } calendar_t;

  class CalendarScoreboard;
    calendar_t         due_q[$];
    logic [ZONE_W-1:0] zone;
    int                errors;

    function new();
      zone   = ZONE_RESET;
      errors = 0;
    endfunction

    static function bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int month_days(int y, int m);
      case (m)
        4, 6, 9, 11: return 30;
        2:           return is_leap(y) ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    static function longint zone_value(logic [ZONE_W-1:0] z);
      longint v;
      v = longint'(z);
      if (z[ZONE_W-1]) v -= longint'(1) << ZONE_W;
      return v;
    endfunction

    function calendar_t to_calendar(logic [SECS_W-1:0] secs);
      longint    local_secs, total_days, days;
      int        sod, yr, mon;
      calendar_t r;
      local_secs = longint'(secs) + zone_value(zone);
      if (local_secs < 0) local_secs = 0;  // clamp to 1900-01-01 00:00:00
      total_days = local_secs / SECS_PER_DAY;
      sod        = int'(local_secs % SECS_PER_DAY);
      days       = total_days;
      yr         = FIRST_YEAR;
      while (days >= (is_leap(yr) ? 366 : 365)) begin
        days -= is_leap(yr) ? 366 : 365;
        yr++;
      end
      mon = 1;
      while (mon < 12 && days >= month_days(yr, mon)) begin
        days -= month_days(yr, mon);
        mon++;
      end
      r.year   = 11'(yr);
      r.month  = 4'(mon);
      r.mday   = 5'(days + 1);
      r.hour   = 5'(sod / SECS_PER_HOUR);
      r.minute = 6'((sod % SECS_PER_HOUR) / SECS_PER_MIN);
      r.second = 6'(sod % SECS_PER_MIN);
      // 1900-01-01 is a Monday
      r.wday   = 3'((total_days + 1) % 7);
      return r;
    endfunction

    function void note_request(logic [SECS_W-1:0] secs);
      due_q.push_back(to_calendar(secs));
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("tb: mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task check_result(calendar_t got);
      calendar_t want;
      if (due_q.size() == 0) begin
        report("result with no request pending");
        return;
      end
      want = due_q.pop_front();
      compare_field("year", got.year, want.year);
      compare_field("month", got.month, want.month);
      compare_field("day_of_month", got.mday, want.mday);
      compare_field("hour", got.hour, want.hour);
      compare_field("minute", got.minute, want.minute);
      compare_field("second", got.second, want.second);
      compare_field("weekday", got.wday, want.wday);
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [SECS_W-1:0] ntp_seconds;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ZONE_W-1:0] zone_offset_seconds;
  logic              out_valid;
  logic              out_stall;
  logic [10:0]       year;
  logic [3:0]        month;
  logic [4:0]        day_of_month;
  logic [4:0]        hour;
  logic [5:0]        minute;
  logic [5:0]        second;
  logic [2:0]        weekday;

  CalendarScoreboard sb;
  bit                in_burst;
  bit                out_burst;
  int                idle_cycles;

  ntp_seconds_to_calendar_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .ntp_seconds         (ntp_seconds),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .zone_offset_seconds (zone_offset_seconds),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .year                (year),
    .month               (month),
    .day_of_month        (day_of_month),
    .hour                (hour),
    .minute              (minute),
    .second              (second),
    .weekday             (weekday)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int draw_wait(bit burst);
    return burst ? 0 : int'($urandom_range(0, 12));
  endfunction

  // Times near a year or month start as often as plain random ones, plus
  // tiny and near-maximum counts.
  function automatic logic [SECS_W-1:0] pick_time();
    longint base, t;
    int     y, m, kind;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom;
    if (kind == 8) return $urandom_range(0, 140000);
    if (kind == 9) return 32'hFFFF_FFFF - $urandom_range(0, 200000);
    y    = $urandom_range(1900, 2036);
    m    = $urandom_range(1, 12);
    base = 0;
    for (int i = FIRST_YEAR; i < y; i++)
      base += CalendarScoreboard::is_leap(i) ? 366 : 365;
    for (int i = 1; i < m; i++)
      base += CalendarScoreboard::month_days(y, i);
    t = base * SECS_PER_DAY + longint'($urandom_range(0, 200000)) - 100000
        - CalendarScoreboard::zone_value(sb.zone);
    if (t < 0 || t > longint'(32'hFFFF_FFFF)) return $urandom;
    return t[SECS_W-1:0];
  endfunction

  task automatic send_time(input logic [SECS_W-1:0] secs);
    int gap;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    ntp_seconds <= secs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(secs);
  endtask

  task automatic send_batch(input logic [SECS_W-1:0] batch[$]);
    foreach (batch[i]) send_time(batch[i]);
  endtask

  // Write the offset only once every pending request has come back.
  task automatic set_zone(input logic [ZONE_W-1:0] z);
    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    cfg_valid           <= 1'b1;
    zone_offset_seconds <= z;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.zone = z;
  endtask

  initial begin : result_side
    int        stall_left;
    calendar_t got;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {year, month, day_of_month, hour, minute, second, weekday};
        sb.check_result(got);
        stall_left = draw_wait(out_burst);
      end
      // count the stall down only while a result is waiting
      if (stall_left > 0) begin
        if (out_valid) stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [SECS_W-1:0] batch[$];
    logic [ZONE_W-1:0] zone_plan[$];
    sb = new();
    in_burst    = 1'b0;
    out_burst   = 1'b0;
    rst                 <= 1'b1;
    in_valid            <= 1'b0;
    ntp_seconds         <= '0;
    cfg_valid           <= 1'b0;
    zone_offset_seconds <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset offset (-10832 s): times that clamp, one late in the first day, top of range
    batch = '{32'd0, 32'd10799, 32'd10800, 32'd97199, 32'hFFFF_FFFF};
    send_batch(batch);

    // no offset: leap rules and year/month edges
    set_zone('0);
    batch = '{32'd5097599, 32'd5097600, 32'd31535999, 32'd31536000,
              32'd131241600, 32'd3155673599, 32'd3160771200, 32'd3160816496,
              32'd3160857600, 32'hAAAA_AAAA, 32'h5555_5555};
    send_batch(batch);

    // most negative 17-bit offset
    set_zone(17'h10000);
    batch = '{32'd0, 32'd65535, 32'd65536, 32'd65537, 32'd151935};
    send_batch(batch);

    // most positive 17-bit offset
    set_zone(17'h0FFFF);
    batch = '{32'd0, 32'hFFFF_0000, 32'hFFFF_FFFF};
    send_batch(batch);

    zone_plan = '{17'(-43200), 17'(50400), ZONE_RESET};
    repeat (4) zone_plan.push_back(17'(int'($urandom_range(0, 93600)) - 43200));
    zone_plan.push_back(17'($urandom));
    foreach (zone_plan[p]) begin
      set_zone(zone_plan[p]);
      in_burst  = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      repeat (PHASE_ITEMS) send_time(pick_time());
    end

    in_valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ntpcal_pkg.sv
sv/ntpcal_dp.sv
sv/ntpcal_ctrl.sv
sv/ntp_seconds_to_calendar_top.sv
dv/tb_top.sv
